/* sv/rbo_pkg.sv */
// package: register codes, pair tables and stage flags for the ray box overlap block
package rbo_pkg;

  localparam int NUM_AXES   = 3;
  localparam int NUM_PAIRS  = 6;
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } reg_idx_t;

  // ordered axis pairs (a, b): entry on b against exit on a
  localparam logic [1:0] PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] PAIR_B [NUM_PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

  typedef struct packed {
    logic                  dir_zero;
    logic [NUM_AXES-1:0]   axis_ok;
    logic [NUM_PAIRS-1:0]  pair_en;
    logic [NUM_PAIRS-1:0]  pair_same;
  } rbo_flags_t;

endpackage

/* sv/rbo_if.sv */
// channel interfaces: box words in, hit words out
interface rbo_box_if #(parameter int COORD_WIDTH = 16);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] box_min_x;
  logic [COORD_WIDTH-1:0] box_min_y;
  logic [COORD_WIDTH-1:0] box_min_z;
  logic [COORD_WIDTH-1:0] box_max_x;
  logic [COORD_WIDTH-1:0] box_max_y;
  logic [COORD_WIDTH-1:0] box_max_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

interface rbo_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

/* sv/rbo_cfg_regs.sv */
// apb register file holding the ray origin and direction
module rbo_cfg_regs #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [rbo_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [rbo_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [rbo_pkg::APB_DATA_W-1:0]        prdata,
  output logic [rbo_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] origin,
  output logic [rbo_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] dir
);
  import rbo_pkg::*;

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] origin_r, origin_nxt;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] dir_r, dir_nxt;
  logic [COORD_WIDTH-1:0]               wval;
  logic [COORD_WIDTH-1:0]               rval;
  reg_idx_t                             idx;
  logic                                 wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign wval  = pwdata[COORD_WIDTH-1:0];

  always_comb begin
    origin_nxt = origin_r;
    dir_nxt    = dir_r;
    if (wr_en) begin
      case (idx)
        REG_ORIGIN_X: origin_nxt[0] = wval;
        REG_ORIGIN_Y: origin_nxt[1] = wval;
        REG_ORIGIN_Z: origin_nxt[2] = wval;
        REG_DIR_X:    dir_nxt[0]    = wval;
        REG_DIR_Y:    dir_nxt[1]    = wval;
        REG_DIR_Z:    dir_nxt[2]    = wval;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      dir_r    <= '0;
    end else begin
      origin_r <= origin_nxt;
      dir_r    <= dir_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_ORIGIN_X: rval = origin_r[0];
      REG_ORIGIN_Y: rval = origin_r[1];
      REG_ORIGIN_Z: rval = origin_r[2];
      REG_DIR_X:    rval = dir_r[0];
      REG_DIR_Y:    rval = dir_r[1];
      REG_DIR_Z:    rval = dir_r[2];
      default:      rval = '0;
    endcase
    prdata                  = '0;
    prdata[COORD_WIDTH-1:0] = rval;
  end

  assign origin = origin_r;
  assign dir    = dir_r;

endmodule

/* sv/rbo_slab_stage.sv */
// box input register, per-axis slab checks and slope cross products
module rbo_slab_stage #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [rbo_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  box_lo,
  input  logic [rbo_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  box_hi,
  input  logic [rbo_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  origin,
  input  logic [rbo_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  dir,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic [rbo_pkg::NUM_PAIRS-1:0][2*COORD_WIDTH:0] prod_lhs,
  output logic [rbo_pkg::NUM_PAIRS-1:0][2*COORD_WIDTH:0] prod_rhs,
  output rbo_pkg::rbo_flags_t                            flags
);
  import rbo_pkg::*;

  localparam int PW = 2 * COORD_WIDTH + 1;

  logic                                 box_v_r;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_r, hi_r;
  logic                                 prod_v_r;
  logic [NUM_PAIRS-1:0][PW-1:0]         lhs_r, rhs_r, lhs_nxt, rhs_nxt;
  rbo_flags_t                           flags_r, flags_nxt;
  logic                                 rdy0, rdy1;

  logic [NUM_AXES-1:0]                  d_neg, d_pos;
  logic [NUM_AXES-1:0][COORD_WIDTH:0]   near_d, far_d;
  logic                                 dir_zero_nxt;
  logic [NUM_AXES-1:0]                  axis_ok_nxt;
  logic [NUM_PAIRS-1:0]                 pair_en_nxt, pair_same_nxt;

  assign rdy1     = !prod_v_r || out_ready;
  assign rdy0     = !box_v_r || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_v_r  <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      if (rdy0) box_v_r <= in_valid;
      if (rdy1) prod_v_r <= box_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      lo_r <= box_lo;
      hi_r <= box_hi;
    end
    if (rdy1 && box_v_r) begin
      lhs_r   <= lhs_nxt;
      rhs_r   <= rhs_nxt;
      flags_r <= flags_nxt;
    end
  end

  // per axis: sign of direction, near/far bound minus origin, slab check
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic signed [COORD_WIDTH-1:0] o_s, lo_s, hi_s;
    logic signed [COORD_WIDTH:0]   lo_m_o, hi_m_o;
    assign o_s    = signed'(origin[a]);
    assign lo_s   = signed'(lo_r[a]);
    assign hi_s   = signed'(hi_r[a]);
    assign d_neg[a] = dir[a][COORD_WIDTH-1];
    assign d_pos[a] = !dir[a][COORD_WIDTH-1] && (|dir[a]);
    assign lo_m_o = {lo_s[COORD_WIDTH-1], lo_s} - {o_s[COORD_WIDTH-1], o_s};
    assign hi_m_o = {hi_s[COORD_WIDTH-1], hi_s} - {o_s[COORD_WIDTH-1], o_s};
    assign near_d[a] = d_neg[a] ? hi_m_o : lo_m_o;
    assign far_d[a]  = d_neg[a] ? lo_m_o : hi_m_o;
    assign axis_ok_nxt[a] = d_neg[a] ? (o_s >= lo_s) :
                            d_pos[a] ? (o_s <= hi_s) :
                                       ((o_s >= lo_s) && (o_s <= hi_s));
  end

  // lhs = (near_b - o_b) * d_a, rhs = (far_a - o_a) * d_b
  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
    localparam int A = int'(PAIR_A[p]);
    localparam int B = int'(PAIR_B[p]);
    logic signed [PW-1:0] nb_x, fa_x, da_x, db_x;
    assign nb_x = signed'({{(COORD_WIDTH){near_d[B][COORD_WIDTH]}}, near_d[B]});
    assign fa_x = signed'({{(COORD_WIDTH){far_d[A][COORD_WIDTH]}}, far_d[A]});
    assign da_x = signed'({{(COORD_WIDTH+1){dir[A][COORD_WIDTH-1]}}, dir[A]});
    assign db_x = signed'({{(COORD_WIDTH+1){dir[B][COORD_WIDTH-1]}}, dir[B]});
    assign lhs_nxt[p] = nb_x * da_x;
    assign rhs_nxt[p] = fa_x * db_x;
    assign pair_en_nxt[p]   = (d_neg[A] || d_pos[A]) && (d_neg[B] || d_pos[B]);
    assign pair_same_nxt[p] = (d_pos[A] == d_pos[B]);
  end

  assign dir_zero_nxt = !(|d_neg) && !(|d_pos);
  assign flags_nxt    = {dir_zero_nxt, axis_ok_nxt, pair_en_nxt, pair_same_nxt};

  assign out_valid = prod_v_r;
  assign prod_lhs  = lhs_r;
  assign prod_rhs  = rhs_r;
  assign flags     = flags_r;

endmodule

/* sv/rbo_cmp_stage.sv */
// slope comparisons and hit result register
module rbo_cmp_stage #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_valid,
  output logic                                           in_ready,
  input  logic [rbo_pkg::NUM_PAIRS-1:0][2*COORD_WIDTH:0] prod_lhs,
  input  logic [rbo_pkg::NUM_PAIRS-1:0][2*COORD_WIDTH:0] prod_rhs,
  input  rbo_pkg::rbo_flags_t                            flags,
  rbo_hit_if.source                                      out_ch
);
  import rbo_pkg::*;

  logic                 hit_v_r;
  logic                 hit_r, hit_nxt;
  logic [NUM_PAIRS-1:0] fail;
  logic                 rdy;

  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_cmp
    logic signed [2*COORD_WIDTH:0] l_s, r_s;
    assign l_s = signed'(prod_lhs[p]);
    assign r_s = signed'(prod_rhs[p]);
    assign fail[p] = flags.pair_en[p] && (flags.pair_same[p] ? (l_s > r_s) : (l_s < r_s));
  end

  assign hit_nxt  = !flags.dir_zero && (&flags.axis_ok) && !(|fail);
  assign rdy      = !hit_v_r || out_ch.ready;
  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_v_r <= 1'b0;
    end else if (rdy) begin
      hit_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_valid) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.valid = hit_v_r;
  assign out_ch.hit   = hit_r;

endmodule

/* sv/ray_box_overlap_slopes.sv */
// top level: ray versus axis-aligned box overlap by ray slopes
//
//  channel  | direction | payload                          | handshake
//  ---------+-----------+----------------------------------+--------------------
//  in_ch    | sink      | box_min_x/y/z, box_max_x/y/z     | valid/ready
//  out_ch   | source    | hit                              | valid/ready
//  cfg_*    | apb slave | ray origin x/y/z, direction x/y/z| psel/penable, pready=1
//
// one box word per cycle sustained while out_ch is ready; registers: box register,
// cross product register (one multiply per slope term), hit register
// synchronous active-low reset clears the valid bits and all ray registers to 0
// a stalled output holds every stage; each stage refills as soon as its word moves on
module ray_box_overlap_slopes #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rbo_box_if.sink                        in_ch,
  rbo_hit_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rbo_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rbo_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output logic [rbo_pkg::APB_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import rbo_pkg::*;

  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  origin, dir;
  logic [NUM_AXES-1:0][COORD_WIDTH-1:0]  box_lo, box_hi;
  logic [NUM_PAIRS-1:0][2*COORD_WIDTH:0] prod_lhs, prod_rhs;
  rbo_flags_t                            flags;
  logic                                  mid_valid, mid_ready;

  assign cfg_pready = 1'b1;

  assign box_lo = {in_ch.box_min_z, in_ch.box_min_y, in_ch.box_min_x};
  assign box_hi = {in_ch.box_max_z, in_ch.box_max_y, in_ch.box_max_x};

  rbo_cfg_regs #(.COORD_WIDTH(COORD_WIDTH)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .origin  (origin),
    .dir     (dir)
  );

  rbo_slab_stage #(.COORD_WIDTH(COORD_WIDTH)) u_slab (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .box_lo    (box_lo),
    .box_hi    (box_hi),
    .origin    (origin),
    .dir       (dir),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .prod_lhs  (prod_lhs),
    .prod_rhs  (prod_rhs),
    .flags     (flags)
  );

  rbo_cmp_stage #(.COORD_WIDTH(COORD_WIDTH)) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mid_valid),
    .in_ready (mid_ready),
    .prod_lhs (prod_lhs),
    .prod_rhs (prod_rhs),
    .flags    (flags),
    .out_ch   (out_ch)
  );

endmodule

/* tb/rbo_hit_checker.sv */
// checker: tracks the ray registers, predicts the hit word for each box and compares
`timescale 1ns / 1ps

module rbo_hit_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rbo_box_if                             box_ch,
  rbo_hit_if                             hit_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic                           cfg_pready,
  input  logic [rbo_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [rbo_pkg::APB_DATA_W-1:0] cfg_pwdata,
  output int                             mismatches,
  output int                             pending
);

  logic signed [COORD_WIDTH-1:0] ray_reg [6];
  logic signed [COORD_WIDTH-1:0] box_lo [3];
  logic signed [COORD_WIDTH-1:0] box_hi [3];
  bit                            hits_due [$];
  bit                            want;
  int                            reg_sel;

  function automatic bit ray_meets_box(input logic signed [COORD_WIDTH-1:0] lo_w [3],
                                       input logic signed [COORD_WIDTH-1:0] hi_w [3]);
    longint o [3];
    longint d [3];
    longint lo [3];
    longint hi [3];
    longint near_v [3];
    longint far_v [3];
    longint lhs;
    longint rhs;
    bit     meets;
    int     a;
    int     b;
    meets = 1'b1;
    for (a = 0; a < 3; a++) begin
      o[a]  = ray_reg[int'(rbo_pkg::REG_ORIGIN_X) + a];
      d[a]  = ray_reg[int'(rbo_pkg::REG_DIR_X) + a];
      lo[a] = lo_w[a];
      hi[a] = hi_w[a];
    end
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      return 1'b0;
    end
    // slab test per axis by direction sign
    for (a = 0; a < 3; a++) begin
      if (d[a] < 0) begin
        if (o[a] < lo[a]) meets = 1'b0;
        near_v[a] = hi[a];
        far_v[a]  = lo[a];
      end else if (d[a] > 0) begin
        if (o[a] > hi[a]) meets = 1'b0;
        near_v[a] = lo[a];
        far_v[a]  = hi[a];
      end else begin
        if (o[a] < lo[a] || o[a] > hi[a]) meets = 1'b0;
        near_v[a] = lo[a];
        far_v[a]  = hi[a];
      end
    end
    // entry on b must not pass exit on a, cross-multiplied
    for (a = 0; a < 3; a++) begin
      for (b = 0; b < 3; b++) begin
        if (a != b && d[a] != 0 && d[b] != 0) begin
          lhs = (near_v[b] - o[b]) * d[a];
          rhs = (far_v[a] - o[a]) * d[b];
          if ((d[a] > 0) == (d[b] > 0)) begin
            if (lhs > rhs) meets = 1'b0;
          end else begin
            if (lhs < rhs) meets = 1'b0;
          end
        end
      end
    end
    return meets;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      hits_due.delete();
      for (reg_sel = 0; reg_sel < 6; reg_sel++) begin
        ray_reg[reg_sel] = '0;
      end
      pending <= 0;
    end else begin
      if (box_ch.valid && box_ch.ready) begin
        box_lo[0] = box_ch.box_min_x;
        box_lo[1] = box_ch.box_min_y;
        box_lo[2] = box_ch.box_min_z;
        box_hi[0] = box_ch.box_max_x;
        box_hi[1] = box_ch.box_max_y;
        box_hi[2] = box_ch.box_max_z;
        hits_due.push_back(ray_meets_box(box_lo, box_hi));
      end
      if (hit_ch.valid && hit_ch.ready) begin
        if (hits_due.size() == 0) begin
          $error("hit: expected none, actual %0b", hit_ch.hit);
          mismatches++;
        end else begin
          want = hits_due.pop_front();
          if (hit_ch.hit !== want) begin
            $error("hit: expected %0b, actual %0b", want, hit_ch.hit);
            mismatches++;
          end
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        reg_sel = int'(cfg_paddr >> 2);
        if (reg_sel <= int'(rbo_pkg::REG_DIR_Z)) begin
          ray_reg[reg_sel] = cfg_pwdata[COORD_WIDTH-1:0];
        end
      end
      pending <= hits_due.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// testbench top: clock, reset, ray register writes, box word stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int COORD_W      = 16;
  localparam int PIPE_LATENCY = 3;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [rbo_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [rbo_pkg::APB_DATA_W-1:0] cfg_pwdata;
  logic [rbo_pkg::APB_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;
  int                             hit_errors;
  int                             hits_waiting;

  bit src_gaps;
  bit sink_stalls;
  int sink_hold;
  int ray_o [3];
  int ray_d [3];
  int phase;
  int k;

  rbo_box_if #(.COORD_WIDTH(COORD_W)) in_ch ();
  rbo_hit_if                          out_ch ();

  ray_box_overlap_slopes #(.COORD_WIDTH(COORD_W)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  rbo_hit_checker #(.COORD_WIDTH(COORD_W)) hit_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .box_ch      (in_ch),
    .hit_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .mismatches  (hit_errors),
    .pending     (hits_waiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int fit_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // mostly short, a few long
  function automatic int pause_len();
    if ($urandom_range(0, 99) < 80) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  function automatic int pick_dir();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 35) return $urandom_range(0, 1) ? 32767 : -32768;
    if (r < 70) return $urandom_range(0, 1) ? int'($urandom_range(1, 64))
                                             : -int'($urandom_range(1, 64));
    return $urandom_range(0, 1) ? int'($urandom_range(1, 32767))
                                : -int'($urandom_range(1, 32768));
  endfunction

  function automatic int pick_origin();
    if ($urandom_range(0, 99) < 70) return int'($urandom_range(0, 2000)) - 1000;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic apb_write(input logic [2:0] index, input logic [COORD_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {index, 2'b00};
    cfg_pwdata  <= {16'($urandom()), value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_ray(input int ox, input int oy, input int oz,
                          input int dx, input int dy, input int dz);
    ray_o = '{ox, oy, oz};
    ray_d = '{dx, dy, dz};
    apb_write(rbo_pkg::REG_ORIGIN_X, 16'(ox));
    apb_write(rbo_pkg::REG_ORIGIN_Y, 16'(oy));
    apb_write(rbo_pkg::REG_ORIGIN_Z, 16'(oz));
    apb_write(rbo_pkg::REG_DIR_X, 16'(dx));
    apb_write(rbo_pkg::REG_DIR_Y, 16'(dy));
    apb_write(rbo_pkg::REG_DIR_Z, 16'(dz));
  endtask

  task automatic offer_box(input int lx, input int ly, input int lz,
                           input int hx, input int hy, input int hz);
    in_ch.valid     <= 1'b1;
    in_ch.box_min_x <= 16'(lx);
    in_ch.box_min_y <= 16'(ly);
    in_ch.box_min_z <= 16'(lz);
    in_ch.box_max_x <= 16'(hx);
    in_ch.box_max_y <= 16'(hy);
    in_ch.box_max_z <= 16'(hz);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic rest_input();
    int n;
    n = src_gaps ? idle_len() : 0;
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (hits_waiting != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // boxes around points on the ray, shifted near misses, and raw random words
  task automatic offer_random_box();
    int lo [3];
    int hi [3];
    int kind;
    int t;
    int sh;
    int rad;
    int p;
    int ax;
    int off;
    int a;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      for (a = 0; a < 3; a++) begin
        lo[a] = int'($urandom_range(0, 65535)) - 32768;
        hi[a] = int'($urandom_range(0, 65535)) - 32768;
      end
    end else begin
      t   = $urandom_range(0, 256);
      sh  = $urandom_range(0, 8);
      rad = (1 << $urandom_range(0, 10)) - 1;
      rad = int'($urandom_range(0, rad));
      for (a = 0; a < 3; a++) begin
        p     = ray_o[a] + ((ray_d[a] * t) >>> sh);
        lo[a] = fit_coord(p - int'($urandom_range(0, rad)));
        hi[a] = fit_coord(p + int'($urandom_range(0, rad)));
      end
      if (kind >= 75) begin
        ax  = $urandom_range(0, 2);
        off = int'($urandom_range(1, rad + 8));
        if ($urandom_range(0, 1)) off = -off;
        lo[ax] = fit_coord(lo[ax] + off);
        hi[ax] = fit_coord(hi[ax] + off);
      end
    end
    offer_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // result side
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (sink_hold) @(posedge clk);
        sink_hold = 0;
      end else if (sink_stalls && $urandom_range(0, 9) < 3) begin
        out_ch.ready <= 1'b0;
        repeat (pause_len()) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.box_min_x <= '0;
    in_ch.box_min_y <= '0;
    in_ch.box_min_z <= '0;
    in_ch.box_max_x <= '0;
    in_ch.box_max_y <= '0;
    in_ch.box_max_z <= '0;
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    sink_hold   = 0;
    ray_o       = '{0, 0, 0};
    ray_d       = '{0, 0, 0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero direction straight out of reset
    offer_box(-32768, -32768, -32768, 32767, 32767, 32767);
    rest_input();
    offer_box(0, 0, 0, 0, 0, 0);
    rest_input();
    offer_box(32767, 32767, 32767, -32768, -32768, -32768);
    settle();

    // writes past the last register must not land anywhere
    load_ray(0, 0, 0, 1, 2, 3);
    for (k = 1; k <= 2; k++) begin
      apb_write(3'(int'(rbo_pkg::REG_DIR_Z) + k), 16'($urandom()));
    end
    offer_box(-32768, -32768, -32768, 32767, 32767, 32767);
    rest_input();
    offer_box(32767, 32767, 32767, -32768, -32768, -32768);
    rest_input();
    offer_box(10, 20, 30, 10, 20, 30);
    rest_input();
    offer_box(11, 20, 30, 11, 20, 30);
    rest_input();
    offer_box(-20, -40, -60, -10, -20, -30);
    rest_input();
    offer_box(0, 0, 0, 0, 0, 0);
    rest_input();
    offer_box(-32768, -32768, -32768, -32768, -32768, -32768);
    rest_input();
    offer_box(32767, 32767, 32767, 32767, 32767, 32767);
    settle();

    load_ray(-32768, -32768, -32768, 32767, 32767, 32767);
    offer_box(-32768, -32768, -32768, 32767, 32767, 32767);
    rest_input();
    offer_box(32767, 32767, 32767, 32767, 32767, 32767);
    rest_input();
    offer_box(-32768, -32768, -32768, -32768, -32768, -32768);
    settle();

    load_ray(32767, 32767, 32767, -32768, -32768, -32768);
    offer_box(-32768, -32768, -32768, 32767, 32767, 32767);
    rest_input();
    offer_box(32767, 32767, 32767, 32767, 32767, 32767);
    rest_input();
    offer_box(-32768, -32768, -32768, -32768, -32768, -32768);
    settle();

    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: load_ray(100, -200, 300, 0, 0, 5);
        1: load_ray(-50, 40, 0, -7, 0, 13);
        2: load_ray(10, 10, 10, 3, -4, 5);
        3: load_ray(-5, 5, -5, -3, -4, 5);
        default: load_ray(pick_origin(), pick_origin(), pick_origin(),
                          pick_dir(), pick_dir(), pick_dir());
      endcase
      src_gaps    = (phase % 3) != 1;
      sink_stalls = (phase % 3) != 1;
      if (phase == 5) begin
        src_gaps  = 1'b0;
        sink_hold = 80;
      end
      repeat (48) begin
        offer_random_box();
        rest_input();
      end
      settle();
    end

    if (hit_errors == 0 && hits_waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
